>>> rtl/mlpq_pkg.sv
`timescale 1ns / 1ps

package mlpq_pkg;

    // Fixed field widths of the request and result channels
    localparam int CMD_W    = 2;
    localparam int LEVEL_W  = 3;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 8;

    // Parameter defaults
    localparam int DEF_PRIO_LEVELS = 8;
    localparam int DEF_LEVEL_DEPTH = 16;
    localparam int DEF_ITEM_WIDTH  = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load_req;   // capture the accepted request
        logic scan;       // pick the target level
        logic act;        // touch the entry memory and the pointers
        logic load_out;   // fill the result register
    } t_dp_cmd;

endpackage

>>> rtl/mlpq_ram.sv
`timescale 1ns / 1ps

module mlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mlpq_ctrl.sv
`timescale 1ns / 1ps

module mlpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mlpq_pkg::t_dp_cmd o_cmd
);

    import mlpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_ACT  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer: accept, scan, act, then hand the result to the output register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                n_state    = S_ACT;
            end
            S_ACT: begin
                o_cmd.act = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/mlpq_dp.sv
`timescale 1ns / 1ps

module mlpq_dp #(
    parameter int PRIO_LEVELS = mlpq_pkg::DEF_PRIO_LEVELS,
    parameter int LEVEL_DEPTH = mlpq_pkg::DEF_LEVEL_DEPTH,
    parameter int ITEM_WIDTH  = mlpq_pkg::DEF_ITEM_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mlpq_pkg::t_dp_cmd               i_cmd_ctl,
    input  logic [mlpq_pkg::CMD_W-1:0]      i_cmd,
    input  logic [mlpq_pkg::LEVEL_W-1:0]    i_level,
    input  logic [mlpq_pkg::ITEM_W-1:0]     i_item,
    output logic [mlpq_pkg::STATUS_W-1:0]   o_status,
    output logic [mlpq_pkg::ITEM_W-1:0]     o_item_out,
    output logic [mlpq_pkg::LEVEL_W-1:0]    o_served_level,
    output logic [mlpq_pkg::TOTAL_W-1:0]    o_total_count
);

    import mlpq_pkg::*;

    localparam int STORE_W = (ITEM_WIDTH < ITEM_W) ? ITEM_WIDTH : ITEM_W;
    localparam int ENTRIES = PRIO_LEVELS * LEVEL_DEPTH;
    localparam int AW      = $clog2(ENTRIES);
    localparam int LW      = $clog2(PRIO_LEVELS);
    localparam int PW      = $clog2(LEVEL_DEPTH);
    localparam int CW      = $clog2(LEVEL_DEPTH + 1);
    localparam int TW      = $clog2(ENTRIES + 1);

    // Per-level queue state
    logic [PW-1:0] r_head  [PRIO_LEVELS];
    logic [PW-1:0] r_tail  [PRIO_LEVELS];
    logic [CW-1:0] r_count [PRIO_LEVELS];
    logic [TW-1:0] r_total;

    // Request and scan registers
    logic [CMD_W-1:0]   r_cmd;
    logic [LEVEL_W-1:0] r_level;
    logic [STORE_W-1:0] r_item;
    logic [LW-1:0]      r_sel;
    logic               r_hit;
    logic               r_is_enq;

    // Result registers
    logic [STATUS_W-1:0] r_status;
    logic [ITEM_W-1:0]   r_item_out;
    logic [LEVEL_W-1:0]  r_served;
    logic [TOTAL_W-1:0]  r_total_out;

    logic               scan_hit;
    logic [LW-1:0]      scan_lvl;
    logic               lvl_ok;
    logic               enq_ok;
    logic [LW-1:0]      req_lvl;
    logic [PW-1:0]      sel_head;
    logic [PW-1:0]      sel_tail;
    logic [PW-1:0]      ptr;
    logic [AW-1:0]      ram_addr;
    logic               ram_we;
    logic               ram_re;
    logic [STORE_W-1:0] ram_rdata;

    assign lvl_ok  = int'(r_level) < PRIO_LEVELS;
    assign req_lvl = LW'(r_level);
    assign enq_ok  = lvl_ok && (r_count[req_lvl] != CW'(LEVEL_DEPTH));

    // Priority encoder: lowest non-empty level at or after the start level
    always_comb begin
        scan_hit = 1'b0;
        scan_lvl = '0;
        for (int l = PRIO_LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0 && l >= int'(r_level)) begin
                scan_hit = 1'b1;
                scan_lvl = LW'(l);
            end
        end
    end

    // Capture request and scan outcome
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load_req) begin
            r_cmd   <= i_cmd;
            r_level <= i_level;
            r_item  <= i_item[STORE_W-1:0];
        end
        if (i_cmd_ctl.scan) begin
            r_is_enq <= (r_cmd == CMD_ENQ);
            if (r_cmd == CMD_ENQ) begin
                r_hit <= enq_ok;
                r_sel <= req_lvl;
            end else if (r_cmd == CMD_DEQ || r_cmd == CMD_PEEK) begin
                r_hit <= scan_hit;
                r_sel <= scan_lvl;
            end else begin
                r_hit <= 1'b0;
                r_sel <= '0;
            end
        end
    end

    // Entry memory access at the selected level
    assign sel_head = r_head[r_sel];
    assign sel_tail = r_tail[r_sel];
    assign ptr      = r_is_enq ? sel_tail : sel_head;
    assign ram_addr = AW'(r_sel) * AW'(LEVEL_DEPTH) + AW'(ptr);
    assign ram_we   = i_cmd_ctl.act && r_hit && r_is_enq;
    assign ram_re   = i_cmd_ctl.act && r_hit && !r_is_enq;

    mlpq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (r_item),
        .o_rdata (ram_rdata)
    );

    // Pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < PRIO_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
            r_total <= '0;
        end else if (i_cmd_ctl.act && r_hit) begin
            if (r_is_enq) begin
                r_tail[r_sel]  <= (sel_tail == PW'(LEVEL_DEPTH - 1)) ? '0 : sel_tail + 1'b1;
                r_count[r_sel] <= r_count[r_sel] + 1'b1;
                r_total        <= r_total + 1'b1;
            end else if (r_cmd == CMD_DEQ) begin
                r_head[r_sel]  <= (sel_head == PW'(LEVEL_DEPTH - 1)) ? '0 : sel_head + 1'b1;
                r_count[r_sel] <= r_count[r_sel] - 1'b1;
                r_total        <= r_total - 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load_out) begin
            r_total_out <= TOTAL_W'(r_total);
            if (r_hit) begin
                r_status   <= ST_OK;
                r_item_out <= r_is_enq ? '0 : ITEM_W'(ram_rdata);
                r_served   <= r_is_enq ? r_level : LEVEL_W'(r_sel);
            end else begin
                r_status   <= r_is_enq ? ST_FULL : ST_EMPTY;
                r_item_out <= '0;
                r_served   <= r_is_enq ? r_level : '0;
            end
        end
    end

    assign o_status       = r_status;
    assign o_item_out     = r_item_out;
    assign o_served_level = r_served;
    assign o_total_count  = r_total_out;

endmodule

>>> rtl/multilevel_priority_fifo.sv
`timescale 1ns / 1ps
// Multilevel priority FIFO: one FIFO of LEVEL_DEPTH handles per level, level 0 first.
// Request channel (i_in_valid / o_in_ready): i_cmd enqueue, dequeue or peek,
// i_level as target level or first level scanned, i_item as handle to enqueue.
// Result channel (o_out_valid / i_out_ready): o_status, o_item_out,
// o_served_level and o_total_count, one result per request.
// Each request runs accept, scan, act, result in turn; a new request is taken
// only after the previous one has handed its result to the result register,
// and while that register drains. The single-port entry memory (registered
// read) and the level scan in its own state set this sequence.
// The result register parts the channels: the next request is accepted while a
// result still waits; if the receiver stalls, the following result holds in
// the controller and o_in_ready stays low until the register frees.
// Reset (synchronous, active low) empties all levels at once; the entry memory
// itself is not cleared and no clearing pass is needed.
module multilevel_priority_fifo #(
    parameter int PRIO_LEVELS = mlpq_pkg::DEF_PRIO_LEVELS,
    parameter int LEVEL_DEPTH = mlpq_pkg::DEF_LEVEL_DEPTH,
    parameter int ITEM_WIDTH  = mlpq_pkg::DEF_ITEM_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mlpq_pkg::CMD_W-1:0]    i_cmd,
    input  logic [mlpq_pkg::LEVEL_W-1:0]  i_level,
    input  logic [mlpq_pkg::ITEM_W-1:0]   i_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mlpq_pkg::STATUS_W-1:0] o_status,
    output logic [mlpq_pkg::ITEM_W-1:0]   o_item_out,
    output logic [mlpq_pkg::LEVEL_W-1:0]  o_served_level,
    output logic [mlpq_pkg::TOTAL_W-1:0]  o_total_count
);

    import mlpq_pkg::*;

    t_dp_cmd dp_cmd;

    // Sequencer
    mlpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd)
    );

    // Queue state, entry memory and result register
    mlpq_dp #(
        .PRIO_LEVELS (PRIO_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .ITEM_WIDTH  (ITEM_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_ctl      (dp_cmd),
        .i_cmd          (i_cmd),
        .i_level        (i_level),
        .i_item         (i_item),
        .o_status       (o_status),
        .o_item_out     (o_item_out),
        .o_served_level (o_served_level),
        .o_total_count  (o_total_count)
    );

endmodule
